>>> rtl/i2cem_pkg.sv
// Shared types and constants for the I2C EEPROM master sequencer.
`default_nettype none

package i2cem_pkg;

    localparam int MaxRes   = 4;
    localparam int ResIdxW  = $clog2(MaxRes);
    localparam int ResCntW  = $clog2(MaxRes + 1);

    typedef enum logic [3:0] {
        PH_ADDR1      = 4'd0,
        PH_CLR1       = 4'd1,
        PH_WADDR      = 4'd2,
        PH_WAIT_WA    = 4'd3,
        PH_WAIT_STOP  = 4'd4,
        PH_ADDR2      = 4'd5,
        PH_CLR2       = 4'd6,
        PH_DATA       = 4'd7,
        PH_WAIT_THIRD = 4'd8,
        PH_STOP       = 4'd9
    } phase_t;

    typedef enum logic [3:0] {
        ACT_NONE     = 4'd0,
        ACT_ADDR_W   = 4'd1,
        ACT_ADDR_R   = 4'd2,
        ACT_SEND     = 4'd3,
        ACT_STOP     = 4'd4,
        ACT_START    = 4'd5,
        ACT_ACK_OFF  = 4'd6,
        ACT_STORE    = 4'd7,
        ACT_IRQ_OFF  = 4'd8,
        ACT_CLR_ADDR = 4'd9,
        ACT_CLR_ERR  = 4'd10
    } act_t;

    typedef enum logic [1:0] {
        CFG_DEV_ADDR   = 2'd0,
        CFG_READ_MODE  = 2'd1,
        CFG_WORD_ADDR  = 2'd2,
        CFG_BYTE_COUNT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic       is_error;
        logic       start_sent;
        logic       address_sent;
        logic       tx_empty;
        logic       rx_full;
        logic       byte_done;
        logic       stop_idle;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
        logic [6:0] error_bits;
    } evt_t;

    typedef struct packed {
        act_t       action;
        logic [7:0] byte_out;
        logic [6:0] clear_mask;
        logic       transfer_done;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] index;
        logic [8:0] value;
    } cfg_wr_t;

    typedef struct packed {
        logic [6:0] device_address;
        logic       read_mode;
        logic [7:0] word_address;
        logic [8:0] byte_count;
    } cfg_regs_t;

    typedef struct packed {
        logic [ResCntW-1:0]      count;
        res_t [MaxRes-1:0]       item;
    } res_list_t;

    // Append one command to a result list; last is filled in on the way out.
    function automatic res_list_t push(res_list_t l, act_t a, logic [7:0] b,
                                       logic [6:0] m, logic d);
        res_list_t r;
        r = l;
        r.item[r.count[ResIdxW-1:0]].action        = a;
        r.item[r.count[ResIdxW-1:0]].byte_out      = b;
        r.item[r.count[ResIdxW-1:0]].clear_mask    = m;
        r.item[r.count[ResIdxW-1:0]].transfer_done = d;
        r.item[r.count[ResIdxW-1:0]].last          = 1'b0;
        r.count = r.count + ResCntW'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/i2cem_chan_if.sv
// Valid/ready channel carrying one payload type.
`default_nettype none

interface i2cem_chan_if #(parameter type data_t = logic);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/i2cem_step.sv
// Transaction phase tracking and command list generation for one event.
`default_nettype none

module i2cem_step #(
    parameter int MAX_BYTES = 256,
    parameter int CW        = 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire i2cem_pkg::evt_t       ev,
    input  wire i2cem_pkg::cfg_regs_t  cfg,
    output i2cem_pkg::res_list_t       list
);
    import i2cem_pkg::*;

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   remaining_reg, remaining_next;
    logic            reading_reg, reading_next;

    logic [CW-1:0]   rem_dec;
    logic            rem_zero, rem_is3, rem_lt3, rem_done;
    logic [CW-1:0]   load_cnt;
    logic [7:0]      abyte;

    assign abyte    = {cfg.device_address, 1'b0};
    assign rem_zero = (remaining_reg == '0);
    assign rem_dec  = rem_zero ? remaining_reg : remaining_reg - CW'(1);
    assign rem_done = (rem_dec == '0);
    assign rem_is3  = (32'(remaining_reg) == 32'd3);
    assign rem_lt3  = (32'(remaining_reg) < 32'd3);

    // Clamp the requested count into 1..MAX_BYTES
    always_comb
    begin
        if (cfg.byte_count == '0)
            load_cnt = CW'(1);
        else if (32'(cfg.byte_count) > 32'(MAX_BYTES))
            load_cnt = CW'(MAX_BYTES);
        else
            load_cnt = CW'(cfg.byte_count);
    end

    // Next state
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        reading_next   = reading_reg;
        if (!ev.is_error)
        begin
            unique case (phase_reg)
                PH_ADDR1:
                    if (ev.start_sent)
                    begin
                        remaining_next = load_cnt;
                        reading_next   = cfg.read_mode;
                        phase_next     = PH_CLR1;
                    end
                PH_CLR1:       if (ev.address_sent) phase_next = PH_WADDR;
                PH_WADDR:      if (ev.tx_empty) phase_next = PH_WAIT_WA;
                PH_WAIT_WA:
                    if (ev.byte_done)
                        phase_next = reading_reg ? PH_WAIT_STOP : PH_DATA;
                PH_WAIT_STOP:  if (ev.stop_idle) phase_next = PH_ADDR2;
                PH_ADDR2:      if (ev.start_sent) phase_next = PH_CLR2;
                PH_CLR2:       if (ev.address_sent) phase_next = PH_DATA;
                PH_DATA:
                    if (reading_reg)
                    begin
                        if (ev.rx_full && !rem_zero)
                        begin
                            if (rem_is3 && !ev.byte_done)
                                phase_next = PH_WAIT_THIRD;
                            else
                            begin
                                remaining_next = rem_dec;
                                if (rem_done)
                                begin
                                    reading_next = 1'b0;
                                    phase_next   = PH_ADDR1;
                                end
                            end
                        end
                    end
                    else if (ev.tx_empty)
                    begin
                        remaining_next = rem_dec;
                        if (rem_done)
                            phase_next = PH_STOP;
                    end
                PH_WAIT_THIRD:
                    if (ev.byte_done)
                    begin
                        remaining_next = rem_dec;
                        phase_next     = PH_DATA;
                        if (rem_done)
                        begin
                            reading_next = 1'b0;
                            phase_next   = PH_ADDR1;
                        end
                    end
                PH_STOP:       phase_next = PH_ADDR1;
                default:       phase_next = PH_ADDR1;
            endcase
        end
    end

    // Command list for this event
    always_comb
    begin
        list = '0;
        if (ev.is_error)
        begin
            if (ev.error_bits != '0)
                list = push(list, ACT_CLR_ERR, 8'd0, ev.error_bits, 1'b0);
            list = push(list, ACT_IRQ_OFF, 8'd0, 7'd0, 1'b0);
        end
        else
        begin
            unique case (phase_reg)
                PH_ADDR1:
                    if (ev.start_sent)
                        list = push(list, ACT_ADDR_W, abyte, 7'd0, 1'b0);
                PH_CLR1:
                    if (ev.address_sent)
                        list = push(list, ACT_CLR_ADDR, 8'd0, 7'd0, 1'b0);
                PH_WADDR:
                    if (ev.tx_empty)
                        list = push(list, ACT_SEND, cfg.word_address, 7'd0, 1'b0);
                PH_WAIT_WA:
                    if (ev.byte_done && reading_reg)
                        list = push(list, ACT_STOP, 8'd0, 7'd0, 1'b0);
                PH_WAIT_STOP:
                    if (ev.stop_idle)
                        list = push(list, ACT_START, 8'd0, 7'd0, 1'b0);
                PH_ADDR2:
                    if (ev.start_sent)
                    begin
                        list = push(list, ACT_ADDR_R, abyte | 8'd1, 7'd0, 1'b0);
                        if (rem_lt3)
                            list = push(list, ACT_ACK_OFF, 8'd0, 7'd0, 1'b0);
                    end
                PH_CLR2:
                    if (ev.address_sent)
                    begin
                        list = push(list, ACT_CLR_ADDR, 8'd0, 7'd0, 1'b0);
                        if (rem_lt3 && !rem_zero)
                            list = push(list, ACT_ACK_OFF, 8'd0, 7'd0, 1'b0);
                    end
                PH_DATA:
                    if (reading_reg)
                    begin
                        if (ev.rx_full && !rem_zero && !(rem_is3 && !ev.byte_done))
                        begin
                            if (rem_is3)
                                list = push(list, ACT_ACK_OFF, 8'd0, 7'd0, 1'b0);
                            list = push(list, ACT_STORE, ev.rx_byte, 7'd0, 1'b0);
                            if (rem_done)
                            begin
                                list = push(list, ACT_STOP, 8'd0, 7'd0, 1'b0);
                                list = push(list, ACT_IRQ_OFF, 8'd0, 7'd0, 1'b1);
                            end
                        end
                    end
                    else if (ev.tx_empty)
                        list = push(list, ACT_SEND, ev.tx_byte, 7'd0, 1'b0);
                PH_WAIT_THIRD:
                    if (ev.byte_done)
                    begin
                        list = push(list, ACT_ACK_OFF, 8'd0, 7'd0, 1'b0);
                        list = push(list, ACT_STORE, ev.rx_byte, 7'd0, 1'b0);
                        if (rem_done)
                        begin
                            list = push(list, ACT_STOP, 8'd0, 7'd0, 1'b0);
                            list = push(list, ACT_IRQ_OFF, 8'd0, 7'd0, 1'b1);
                        end
                    end
                PH_STOP:
                begin
                    list = push(list, ACT_STOP, 8'd0, 7'd0, 1'b0);
                    list = push(list, ACT_IRQ_OFF, 8'd0, 7'd0, 1'b1);
                end
                default: list = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ADDR1;
            remaining_reg <= '0;
            reading_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            reading_reg   <= reading_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2cem_drain.sv
// Result buffer: holds one event's command list and hands it out one per transfer.
`default_nettype none

module i2cem_drain (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire i2cem_pkg::res_list_t  list,
    output logic                       can_take,
    i2cem_chan_if.source               res
);
    import i2cem_pkg::*;

    res_list_t             list_reg;
    logic [ResCntW-1:0]    count_reg;
    logic [ResIdxW-1:0]    idx_reg;
    logic                  out_xfer, final_xfer, is_last;

    assign is_last    = (ResCntW'(idx_reg) == count_reg - ResCntW'(1));
    assign out_xfer   = res.valid && res.ready;
    assign final_xfer = out_xfer && is_last;
    assign can_take   = (count_reg == '0) || final_xfer;

    assign res.valid  = (count_reg != '0);

    always_comb
    begin
        res.data      = list_reg.item[idx_reg];
        res.data.last = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load && can_take)
        begin
            count_reg <= list.count;
            idx_reg   <= '0;
        end
        else if (final_xfer)
            count_reg <= '0;
        else if (out_xfer)
            idx_reg <= idx_reg + ResIdxW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load && can_take)
            list_reg <= list;
    end

endmodule

`default_nettype wire

>>> rtl/i2c_eeprom_master_sequencer.sv
// Top level of the I2C EEPROM master sequencer.
//
//  channel  dir  payload     transfer when
//  evt      in   evt_t       evt.valid && evt.ready
//  res      out  res_t       res.valid && res.ready
//  cfg      in   cfg_wr_t    cfg.valid && cfg.ready (always ready)
//
// An event is registered, decoded combinationally into a list of up to three
// commands, and the list is handed out one command per cycle while res.ready is high.
// Sustained rate is one event per cycle for events with at most one command while res.ready is high;
// an event with k commands occupies the result buffer until all k have been transferred.
// Events with no command pass through without reaching the output.
// Reset puts the phase at the first address phase with a zero count.
`default_nettype none

module i2c_eeprom_master_sequencer #(
    parameter int MAX_BYTES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    i2cem_chan_if.sink      evt,
    i2cem_chan_if.source    res,
    i2cem_chan_if.sink      cfg
);
    import i2cem_pkg::*;

    localparam int CapBytes = (MAX_BYTES < 511) ? MAX_BYTES : 511;
    localparam int CW       = $clog2(CapBytes + 1);

    cfg_regs_t  cfg_reg;
    evt_t       ev_reg;
    logic       ev_valid_reg;
    res_list_t  list;
    logic       can_take, adv;
    cfg_wr_t    wr;

    assign wr        = cfg.data;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= 7'd80;
            cfg_reg.read_mode      <= 1'b0;
            cfg_reg.word_address   <= 8'd0;
            cfg_reg.byte_count     <= 9'd1;
        end
        else if (cfg.valid)
        begin
            unique case (wr.index)
                CFG_DEV_ADDR:   cfg_reg.device_address <= wr.value[6:0];
                CFG_READ_MODE:  cfg_reg.read_mode      <= wr.value[0];
                CFG_WORD_ADDR:  cfg_reg.word_address   <= wr.value[7:0];
                CFG_BYTE_COUNT: cfg_reg.byte_count     <= wr.value;
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Input register advances into the decoder when the result buffer frees up
    assign adv       = ev_valid_reg && can_take;
    assign evt.ready = !ev_valid_reg || can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_valid_reg <= 1'b0;
        else if (evt.ready)
            ev_valid_reg <= evt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
            ev_reg <= evt.data;
    end

    i2cem_step #(
        .MAX_BYTES (MAX_BYTES),
        .CW        (CW)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (adv),
        .ev    (ev_reg),
        .cfg   (cfg_reg),
        .list  (list)
    );

    i2cem_drain u_drain (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv),
        .list     (list),
        .can_take (can_take),
        .res      (res)
    );

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !ev_valid_reg |-> evt.ready)
        else $error("event input stalled with empty input register");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.transfer_done |-> res.data.last)
        else $error("transfer_done on a non-final command");

    a_no_null_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.data.action != ACT_NONE)
        else $error("null command presented");

    a_mask_only_clr: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.action != ACT_CLR_ERR |-> res.data.clear_mask == 7'd0)
        else $error("clear mask on a command other than clear errors");

endmodule

`default_nettype wire
